// ----- sv/ssp_pkg.sv -----
// shared types and constants for the serpentine scan position generator
// holds the item, result and internal job structs; no dependencies
package ssp_pkg;

    localparam int POS_W      = 12;
    localparam int CNT_W      = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;
    localparam int JOB_DEPTH  = 2;
    localparam int OUT_DEPTH  = 4;

    // item action codes
    localparam logic [1:0] ACT_START   = 2'd0;
    localparam logic [1:0] ACT_ADVANCE = 2'd1;
    localparam logic [1:0] ACT_WRITE   = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NUM_POINTS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_LINES    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_X_STEP       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_Y_STEP       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_STEP   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_RISING = 3'd5;

    typedef struct packed {
        logic [1:0]       action;
        logic [POS_W-1:0] table_index;
        logic [POS_W-1:0] table_value;
    } t_in_item;

    typedef struct packed {
        logic [POS_W-1:0] x_first_code;
        logic [POS_W-1:0] x_second_code;
        logic [POS_W-1:0] y_first_code;
        logic [POS_W-1:0] y_second_code;
        logic [POS_W-1:0] level_code;
        logic             point_valid;
        logic             scan_done;
        logic [POS_W-1:0] line_number;
        logic             reverse_pass;
    } t_result;

    // result fields that do not come from the table
    typedef struct packed {
        logic [POS_W-1:0] level_code;
        logic             point_valid;
        logic             scan_done;
        logic [POS_W-1:0] line_number;
        logic             reverse_pass;
    } t_meta;

    // work handed from the front to the back: optional table write, then
    // four lookups (x first, x second, y first, y second)
    typedef struct packed {
        logic                  do_write;
        logic [POS_W-1:0]      wr_index;
        logic [POS_W-1:0]      wr_value;
        logic [3:0][POS_W-1:0] pos;
        t_meta                 meta;
    } t_job;

endpackage

// ----- sv/serpentine_scan_position_generator.sv -----
// Serpentine scan position generator. An item is taken whenever full is low,
// one per cycle until the two-entry job queue fills; the front updates the scan
// state in the cycle of acceptance. The back end serves jobs from one
// single-port linearization table: four lookups per item, plus a table write
// for a table write item. It loads another job in the cycle of the current
// job's last lookup when the result queue has room. Table entries read before
// they are written return undefined codes. Depends on ssp_pkg, ssp_fifo,
// ssp_front, ssp_back.
module serpentine_scan_position_generator
    import ssp_pkg::*;
#(
    parameter int TABLE_DEPTH = 4096,
    parameter int CODE_MAX    = 4095
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  push,
    output logic                  full,
    input  t_in_item              i_item,
    output logic                  empty,
    input  logic                  pop,
    output t_result               o_result
);

    t_job                           front_job;
    t_job                           q_job;
    logic                           accept;
    logic                           q_empty;
    logic                           q_pop;
    logic                           res_push;
    t_result                        res;
    logic                           res_full;
    logic [$clog2(OUT_DEPTH+1)-1:0] res_count;

    assign accept = push && !full;

    ssp_front #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .CODE_MAX    (CODE_MAX)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_item      (i_item),
        .o_job       (front_job)
    );

    ssp_fifo #(
        .DEPTH (JOB_DEPTH),
        .T     (t_job)
    ) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (front_job),
        .i_pop   (q_pop),
        .o_data  (q_job),
        .o_full  (full),
        .o_empty (q_empty),
        .o_count ()
    );

    ssp_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (q_job),
        .i_job_valid (!q_empty),
        .o_job_pop   (q_pop),
        .i_out_count (res_count),
        .o_res_push  (res_push),
        .o_res       (res)
    );

    // back end reserves room before starting a job, so res_full never blocks a push
    ssp_fifo #(
        .DEPTH (OUT_DEPTH),
        .T     (t_result)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push && !res_full),
        .i_data  (res),
        .i_pop   (pop),
        .o_data  (o_result),
        .o_full  (res_full),
        .o_empty (empty),
        .o_count (res_count)
    );

endmodule

// ----- sv/ssp_fifo.sv -----
// small register queue used between the front and back and on the result side
// depends on nothing; DEPTH must be a power of two, at least 2
module ssp_fifo #(
    parameter int DEPTH = 2,
    parameter type T = logic
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  T                           i_data,
    input  logic                       i_pop,
    output T                           o_data,
    output logic                       o_full,
    output logic                       o_empty,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    T                r_mem [DEPTH];
    logic [PW-1:0]   r_wp;
    logic [PW-1:0]   r_rp;
    logic [CW-1:0]   r_cnt;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_count = r_cnt;
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + PW'(1);
            end
            if (do_pop) begin
                r_rp <= r_rp + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

// ----- sv/ssp_front.sv -----
// front end: configuration registers, scan state and per-item classification
// depends on ssp_pkg; turns each accepted item into one job for the back end
module ssp_front
    import ssp_pkg::*;
#(
    parameter int TABLE_DEPTH = 4096,
    parameter int CODE_MAX    = 4095
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_accept,
    input  t_in_item              i_item,
    output t_job                  o_job
);

    localparam logic [POS_W-1:0] CODE_LIM = POS_W'(CODE_MAX);

    function automatic logic [POS_W-1:0] sat_add(input logic [POS_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = {2'b00, a} + {1'b0, b};
        return (s > (CNT_W+1)'(CODE_MAX)) ? CODE_LIM : s[POS_W-1:0];
    endfunction

    function automatic logic [POS_W-1:0] sat_sub(input logic [POS_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        logic [CNT_W-1:0] d;
        d = {1'b0, a} - b;
        return ({1'b0, a} > b) ? d[POS_W-1:0] : '0;
    endfunction

    // configuration
    logic [CNT_W-1:0] r_num_points;
    logic [CNT_W-1:0] r_num_lines;
    logic [CNT_W-1:0] r_x_step;
    logic [CNT_W-1:0] r_y_step;
    logic [POS_W-1:0] r_level_step;
    logic             r_level_rising;

    // scan state
    logic [POS_W-1:0] r_x1, r_x2, r_y1, r_y2, r_level;
    logic [CNT_W-1:0] r_point_cnt, r_line_cnt;
    logic             r_pass, r_fwd, r_at_start, r_hold;

    logic [POS_W-1:0] n_x1, n_x2, n_y1, n_y2, n_level;
    logic [CNT_W-1:0] n_point_cnt, n_line_cnt;
    logic             n_pass, n_fwd, n_at_start, n_hold;

    logic [CNT_W-1:0] np;
    logic             valid;
    logic             done;

    always_comb begin
        n_x1        = r_x1;
        n_x2        = r_x2;
        n_y1        = r_y1;
        n_y2        = r_y2;
        n_level     = r_level;
        n_point_cnt = r_point_cnt;
        n_line_cnt  = r_line_cnt;
        n_pass      = r_pass;
        n_fwd       = r_fwd;
        n_at_start  = r_at_start;
        n_hold      = r_hold;
        valid       = 1'b0;
        done        = 1'b0;
        np          = (r_num_points == '0) ? CNT_W'(1) : r_num_points;

        case (i_item.action)
            ACT_START: begin
                n_x1        = CODE_LIM;
                n_x2        = '0;
                n_y1        = CODE_LIM;
                n_y2        = '0;
                n_level     = r_level_rising ? '0 : CODE_LIM;
                n_point_cnt = '0;
                n_line_cnt  = '0;
                n_pass      = 1'b0;
                n_fwd       = 1'b1;
                n_at_start  = 1'b1;
                n_hold      = 1'b0;
            end
            ACT_ADVANCE: begin
                // end of pass; the backward pass also closes the line
                if (r_line_cnt < r_num_lines && r_point_cnt >= np) begin
                    n_point_cnt = '0;
                    n_hold      = 1'b1;
                    n_fwd       = ~r_fwd;
                    if (!r_pass) begin
                        n_pass = 1'b1;
                    end else begin
                        n_pass     = 1'b0;
                        n_y1       = sat_sub(r_y1, r_y_step);
                        n_y2       = sat_add(r_y2, r_y_step);
                        n_level    = r_level_rising ?
                                     sat_add(r_level, {1'b0, r_level_step}) :
                                     sat_sub(r_level, {1'b0, r_level_step});
                        n_line_cnt = r_line_cnt + CNT_W'(1);
                    end
                end
                if (n_line_cnt < r_num_lines) begin
                    if (r_at_start) begin
                        n_at_start = 1'b0;
                    end else if (n_hold) begin
                        n_hold = 1'b0;
                    end else if (n_fwd) begin
                        n_x1 = sat_sub(r_x1, r_x_step);
                        n_x2 = sat_add(r_x2, r_x_step);
                    end else begin
                        n_x1 = sat_add(r_x1, r_x_step);
                        n_x2 = sat_sub(r_x2, r_x_step);
                    end
                    n_point_cnt = n_point_cnt + CNT_W'(1);
                    valid       = 1'b1;
                end else begin
                    n_line_cnt = '0;
                    done       = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_job.do_write = (i_item.action == ACT_WRITE) &&
                         (32'(i_item.table_index) < TABLE_DEPTH);
        o_job.wr_index = i_item.table_index;
        o_job.wr_value = (i_item.table_value > CODE_LIM) ? CODE_LIM : i_item.table_value;
        o_job.pos[0]   = n_x1;
        o_job.pos[1]   = n_x2;
        o_job.pos[2]   = n_y1;
        o_job.pos[3]   = n_y2;
        o_job.meta.level_code   = n_level;
        o_job.meta.point_valid  = valid;
        o_job.meta.scan_done    = done;
        o_job.meta.line_number  = n_line_cnt[POS_W-1:0];
        o_job.meta.reverse_pass = n_pass;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_points   <= CNT_W'(1);
            r_num_lines    <= CNT_W'(1);
            r_x_step       <= '0;
            r_y_step       <= '0;
            r_level_step   <= '0;
            r_level_rising <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_NUM_POINTS:   r_num_points   <= i_cfg_data;
                REG_NUM_LINES:    r_num_lines    <= i_cfg_data;
                REG_X_STEP:       r_x_step       <= i_cfg_data;
                REG_Y_STEP:       r_y_step       <= i_cfg_data;
                REG_LEVEL_STEP:   r_level_step   <= i_cfg_data[POS_W-1:0];
                REG_LEVEL_RISING: r_level_rising <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x1        <= CODE_LIM;
            r_x2        <= '0;
            r_y1        <= CODE_LIM;
            r_y2        <= '0;
            r_level     <= '0;
            r_point_cnt <= '0;
            r_line_cnt  <= '0;
            r_pass      <= 1'b0;
            r_fwd       <= 1'b1;
            r_at_start  <= 1'b1;
            r_hold      <= 1'b0;
        end else if (i_accept) begin
            r_x1        <= n_x1;
            r_x2        <= n_x2;
            r_y1        <= n_y1;
            r_y2        <= n_y2;
            r_level     <= n_level;
            r_point_cnt <= n_point_cnt;
            r_line_cnt  <= n_line_cnt;
            r_pass      <= n_pass;
            r_fwd       <= n_fwd;
            r_at_start  <= n_at_start;
            r_hold      <= n_hold;
        end
    end

endmodule

// ----- sv/ssp_back.sv -----
// back end: linearization table and the lookup sequencer
// depends on ssp_pkg; one memory port does the optional write and four reads per job
module ssp_back
    import ssp_pkg::*;
#(
    parameter int TABLE_DEPTH = 4096
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  t_job                           i_job,
    input  logic                           i_job_valid,
    output logic                           o_job_pop,
    input  logic [$clog2(OUT_DEPTH+1)-1:0] i_out_count,
    output logic                           o_res_push,
    output t_result                        o_res
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(OUT_DEPTH + 1);

    function automatic logic [AW-1:0] to_addr(input logic [POS_W-1:0] p);
        logic [31:0] w;
        w = 32'(p);
        return w[AW-1:0];
    endfunction

    logic [POS_W-1:0] r_mem [TABLE_DEPTH];

    t_job             r_job;
    logic             r_act;
    logic             r_wr_pend;
    logic [1:0]       r_ph;
    logic [CW-1:0]    r_infl;

    // read return pipeline
    logic             r_rv;
    logic [1:0]       r_rk;
    logic             r_rinr;
    logic [POS_W-1:0] r_rd_data;

    logic [POS_W-1:0] r_code0, r_code1, r_code2;
    t_meta            r_meta;

    logic             issue;
    logic             last;
    logic             credit;
    logic             load;
    logic [POS_W-1:0] rd_pos;
    logic [POS_W-1:0] code;
    logic [CW:0]      pending;

    assign issue   = r_act && !r_wr_pend;
    assign last    = issue && (r_ph == 2'd3);
    assign pending = {1'b0, i_out_count} + {1'b0, r_infl};
    assign credit  = pending < (CW+1)'(OUT_DEPTH);
    assign load    = (!r_act || last) && i_job_valid && credit;
    assign rd_pos  = r_job.pos[r_ph];
    assign code    = r_rinr ? r_rd_data : '0;

    assign o_job_pop  = load;
    assign o_res_push = r_rv && (r_rk == 2'd3);

    always_comb begin
        o_res.x_first_code  = r_code0;
        o_res.x_second_code = r_code1;
        o_res.y_first_code  = r_code2;
        o_res.y_second_code = code;
        o_res.level_code    = r_meta.level_code;
        o_res.point_valid   = r_meta.point_valid;
        o_res.scan_done     = r_meta.scan_done;
        o_res.line_number   = r_meta.line_number;
        o_res.reverse_pass  = r_meta.reverse_pass;
    end

    // single port: a write and a read never fall in the same cycle
    always_ff @(posedge i_clk) begin
        if (r_act && r_wr_pend) begin
            r_mem[to_addr(r_job.wr_index)] <= r_job.wr_value;
        end
        if (issue) begin
            r_rd_data <= r_mem[to_addr(rd_pos)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_job <= i_job;
        end
        if (issue) begin
            r_rk   <= r_ph;
            r_rinr <= (32'(rd_pos) < TABLE_DEPTH);
        end
        if (last) begin
            r_meta <= r_job.meta;
        end
        if (r_rv) begin
            case (r_rk)
                2'd0:    r_code0 <= code;
                2'd1:    r_code1 <= code;
                2'd2:    r_code2 <= code;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act     <= 1'b0;
            r_wr_pend <= 1'b0;
            r_ph      <= '0;
            r_rv      <= 1'b0;
            r_infl    <= '0;
        end else begin
            r_rv <= issue;
            if (load) begin
                r_act     <= 1'b1;
                r_wr_pend <= i_job.do_write;
                r_ph      <= '0;
            end else begin
                if (last) begin
                    r_act <= 1'b0;
                end
                if (r_act && r_wr_pend) begin
                    r_wr_pend <= 1'b0;
                end
                if (issue && !last) begin
                    r_ph <= r_ph + 2'd1;
                end
            end
            if (load && !o_res_push) begin
                r_infl <= r_infl + CW'(1);
            end else if (o_res_push && !load) begin
                r_infl <= r_infl - CW'(1);
            end
        end
    end

`ifndef SYNTHESIS
    a_no_out_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |-> (i_out_count < CW'(OUT_DEPTH)))
        else $error("result pushed into a full queue");

    a_load_between_jobs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |-> (!r_act || last))
        else $error("job loaded while another is mid-sequence");

    a_write_then_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_act && r_wr_pend) |=> (issue && (r_ph == 2'd0)))
        else $error("table write not followed by the first lookup");

    a_push_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |=> !o_res_push)
        else $error("two results in consecutive cycles");
`endif

endmodule
